FILE: hw/rtl/gha_pkg.sv
// shared types and constants of the generational handle allocator
package gha_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned HANDLE_W = 18;
  localparam int unsigned STATUS_W = 2;

  // request operation codes
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage

FILE: hw/rtl/gha_if.sv
// request and response channel interfaces of the handle allocator
interface gha_req_if import gha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output op, output handle, input ready);
  modport sink   (input valid, input op, input handle, output ready);
endinterface

interface gha_rsp_if import gha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] new_handle;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output new_handle, output status, input ready);
  modport sink   (input valid, input new_handle, input status, output ready);
endinterface

FILE: hw/rtl/gha_ram.sv
// generic simple dual-port ram with registered read
module gha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/generational_handle_allocator_unit.sv
// top level of the generational handle allocator
//
// usage:
//   req_i carries one request per beat: op (acquire, release, clear) and,
//   for a release, the handle to give back. rsp_o returns exactly one beat
//   per request: the new handle of a successful acquire (zero otherwise)
//   and a status (ok, table full, stale or dead handle).
// sequence:
//   a request is handled in order: the accept cycle issues the reads of the
//   slot table and of the free-index queue; the execute state that follows
//   checks, writes back and loads the response register. no new request
//   is taken until that execute state is done: the single read-modify-write
//   of the slot table must complete first.
// reset and clear:
//   reset and a clear request both leave only reserved slot 0; a clear is
//   done in one request, since slots at or above the slot count are never
//   looked up and every appended slot is rewritten when it is appended.
// backpressure:
//   a response waiting on rsp_o does not block the next accept; the block
//   only holds in its execute cycle until the response register is free.
module generational_handle_allocator_unit import gha_pkg::*; #(
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned GEN_BITS   = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  gha_req_if.sink    req_i,
  gha_rsp_if.source  rsp_o
);

  localparam int unsigned Depth  = 1 << INDEX_BITS;
  localparam int unsigned SlotW  = GEN_BITS + 1;
  localparam int unsigned FifoW  = GEN_BITS + INDEX_BITS;

  // control state
  state_e                  state_q, state_d;
  logic [INDEX_BITS-1:0]   slot_count_q, slot_count_d;
  logic [INDEX_BITS-1:0]   free_head_q, free_head_d;
  logic [INDEX_BITS:0]     free_fill_q, free_fill_d;
  logic                    rsp_valid_q, rsp_valid_d;

  // latched request and response payload
  logic [OP_W-1:0]         op_q;
  logic [INDEX_BITS-1:0]   hidx_q;
  logic [GEN_BITS-1:0]     hgen_q;
  logic [HANDLE_W-1:0]     new_handle_q, new_handle_d;
  logic [STATUS_W-1:0]     status_q, status_d;

  // memory ports
  logic                    accept;
  logic [INDEX_BITS-1:0]   req_idx;
  logic [GEN_BITS-1:0]     req_gen;
  logic                    slot_we;
  logic [INDEX_BITS-1:0]   slot_waddr;
  logic [SlotW-1:0]        slot_wdata;
  logic [SlotW-1:0]        slot_rdata;
  logic                    fifo_we;
  logic [INDEX_BITS-1:0]   fifo_waddr;
  logic [FifoW-1:0]        fifo_wdata;
  logic [FifoW-1:0]        fifo_rdata;

  // execute-cycle decode
  logic                    fire;
  logic                    slot_live;
  logic [GEN_BITS-1:0]     slot_gen;
  logic [INDEX_BITS-1:0]   fifo_idx;
  logic [GEN_BITS-1:0]     fifo_gen;
  logic                    acq_from_fifo;
  logic                    acq_full;
  logic [INDEX_BITS-1:0]   acq_idx;
  logic [GEN_BITS-1:0]     acq_gen;
  logic                    rel_ok;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // split handle: index in the low bits, generation above
  assign req_idx = INDEX_BITS'(req_i.handle);
  assign req_gen = GEN_BITS'(req_i.handle >> INDEX_BITS);

  // slot table: {live, generation} per slot
  gha_ram #(
    .WIDTH (SlotW),
    .DEPTH (Depth)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (accept),
    .raddr_i (req_idx),
    .rdata_o (slot_rdata)
  );

  // free queue: {generation at release, index}, so reuse needs no slot read
  gha_ram #(
    .WIDTH (FifoW),
    .DEPTH (Depth)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .re_i    (accept),
    .raddr_i (free_head_q),
    .rdata_o (fifo_rdata)
  );

  assign slot_live = slot_rdata[GEN_BITS];
  assign slot_gen  = slot_rdata[GEN_BITS-1:0];
  assign fifo_idx  = fifo_rdata[INDEX_BITS-1:0];
  assign fifo_gen  = fifo_rdata[FifoW-1:INDEX_BITS];

  // execute only when the response register can take the result
  assign fire = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);

  // acquire: oldest freed slot first, else append, else full
  assign acq_from_fifo = (free_fill_q != '0);
  assign acq_full      = !acq_from_fifo && (slot_count_q == '1);
  assign acq_idx       = acq_from_fifo ? fifo_idx : slot_count_q;
  assign acq_gen       = acq_from_fifo ? fifo_gen + GEN_BITS'(1) : GEN_BITS'(1);

  // release: slot 0 is never live; index must be appended, live, same generation
  assign rel_ok = (hidx_q != '0) && (hidx_q < slot_count_q) && slot_live &&
                  (slot_gen == hgen_q);

  always_comb begin
    state_d      = state_q;
    slot_count_d = slot_count_q;
    free_head_d  = free_head_q;
    free_fill_d  = free_fill_q;
    rsp_valid_d  = rsp_valid_q;
    new_handle_d = new_handle_q;
    status_d     = status_q;
    slot_we      = 1'b0;
    slot_waddr   = hidx_q;
    slot_wdata   = {1'b0, slot_gen};
    fifo_we      = 1'b0;
    fifo_waddr   = free_head_q + free_fill_q[INDEX_BITS-1:0];
    fifo_wdata   = {slot_gen, hidx_q};

    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d      = S_IDLE;
          rsp_valid_d  = 1'b1;
          new_handle_d = '0;
          status_d     = ST_OK;
          case (op_q)
            OP_ACQUIRE: begin
              if (acq_full) begin
                status_d = ST_FULL;
              end else begin
                slot_we      = 1'b1;
                slot_waddr   = acq_idx;
                slot_wdata   = {1'b1, acq_gen};
                new_handle_d = HANDLE_W'({acq_gen, acq_idx});
                if (acq_from_fifo) begin
                  free_head_d = free_head_q + INDEX_BITS'(1);
                  free_fill_d = free_fill_q - (INDEX_BITS+1)'(1);
                end else begin
                  slot_count_d = slot_count_q + INDEX_BITS'(1);
                end
              end
            end
            OP_RELEASE: begin
              if (rel_ok) begin
                slot_we = 1'b1;
                if (free_fill_q != (INDEX_BITS+1)'(Depth)) begin
                  fifo_we     = 1'b1;
                  free_fill_d = free_fill_q + (INDEX_BITS+1)'(1);
                end
              end else begin
                status_d = ST_STALE;
              end
            end
            OP_CLEAR: begin
              slot_count_d = INDEX_BITS'(1);
              free_head_d  = '0;
              free_fill_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_count_q <= INDEX_BITS'(1);
      free_head_q  <= '0;
      free_fill_q  <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_count_q <= slot_count_d;
      free_head_q  <= free_head_d;
      free_fill_q  <= free_fill_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.op;
      hidx_q <= req_idx;
      hgen_q <= req_gen;
    end
    new_handle_q <= new_handle_d;
    status_q     <= status_d;
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.new_handle = new_handle_q;
  assign rsp_o.status     = status_q;

  // every queued index is a distinct appended slot other than slot 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_fill_q < {1'b0, slot_count_q})
    else $error("free queue holds more entries than appended slots");

  // an accepted request always moves to the execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted request did not reach execute");

  // a response beat only appears after an execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_EXEC))
    else $error("response raised without an execute cycle");

  // a failed operation never hands out a handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (status_q != ST_OK)) |-> (new_handle_q == '0))
    else $error("nonzero handle with failure status");

endmodule
